// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH_DEFAULT         = 16;
   localparam int PRIORITY_BITS_DEFAULT = 16;

   localparam int FIELD_PRIO_BITS  = 16;
   localparam int FIELD_TAG_BITS   = 16;
   localparam int FIELD_COUNT_BITS = 5;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef struct packed {
      logic                       mode;
      logic [FIELD_PRIO_BITS-1:0] priority_req;
      logic [FIELD_TAG_BITS-1:0]  tag;
   } req_type;

   typedef struct packed {
      logic                        accepted;
      logic [FIELD_COUNT_BITS-1:0] count;
      logic                        is_empty;
      logic                        is_full;
      logic [FIELD_PRIO_BITS-1:0]  top_priority;
      logic [FIELD_TAG_BITS-1:0]   top_tag;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture the incoming item
      logic exec;   // update the store and load the result register
   } cmd_type;

endpackage

// ===== sv/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: takes an item, then runs the store update once the result
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold the item until the previous result has been taken
            if (out_free) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Row of compare-and-shift cells holding the entries, highest priority in
// cell 0, plus the entry count and the result register.
// ----------------------------------------------------------------------------
module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   req_type                           req_ff;
   rsp_type                           rsp_ff, rsp_in;
   logic [DEPTH-1:0][PRIORITY_BITS-1:0]  prio_ff, prio_in;
   logic [DEPTH-1:0][FIELD_TAG_BITS-1:0] tag_ff, tag_in;
   logic [CNT_BITS-1:0]               count_ff, count_in;
   logic [DEPTH-1:0]                  ge;
   logic [PRIORITY_BITS-1:0]          prio_new;
   logic                              do_insert, do_remove;

   assign prio_new  = PRIORITY_BITS'(req_ff.priority_req);
   assign do_insert = cmd.exec && (req_ff.mode == MODE_INSERT)
                      && (count_ff != CNT_BITS'(DEPTH));
   assign do_remove = cmd.exec && (req_ff.mode == MODE_REMOVE)
                      && (count_ff != '0);

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         // live entry that stays above a new one of this priority
         assign ge[i] = (CNT_BITS'(i) < count_ff) && (prio_ff[i] >= prio_new);
      end
   endgenerate

   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      for (int c = 0; c < DEPTH; c++) begin
         if (do_insert && !ge[c]) begin
            if ((c == 0) || ge[(c == 0) ? 0 : c-1]) begin
               prio_in[c] = prio_new;
               tag_in[c]  = req_ff.tag;
            end else begin
               prio_in[c] = prio_ff[(c == 0) ? 0 : c-1];
               tag_in[c]  = tag_ff[(c == 0) ? 0 : c-1];
            end
         end else if (do_remove && (c < DEPTH-1)) begin
            prio_in[c] = prio_ff[(c < DEPTH-1) ? c+1 : c];
            tag_in[c]  = tag_ff[(c < DEPTH-1) ? c+1 : c];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_remove) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      rsp_in.accepted = do_insert || do_remove;
      rsp_in.count    = FIELD_COUNT_BITS'(count_in);
      rsp_in.is_empty = (count_in == '0);
      rsp_in.is_full  = (count_in == CNT_BITS'(DEPTH));
      if (count_in != '0) begin
         rsp_in.top_priority = FIELD_PRIO_BITS'(prio_in[0]);
         rsp_in.top_tag      = tag_in[0];
      end else begin
         rsp_in.top_priority = '0;
         rsp_in.top_tag      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (do_insert || do_remove) begin
         prio_ff <= prio_in;
         tag_ff  <= tag_in;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// Result: the item is captured, then the store is updated and the result register
// loaded; the update waits while an earlier result still waits to be taken.
// A new item is taken only once the previous one has updated the store, set by the
// capture-then-update sequence of the controller around the row of compare-and-shift cells.
// Reset: synchronous; empties the queue at once, no clearing pass.
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue kept as a sorted row of entries; equal priorities
// leave in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
   import spq_pkg::*;
#(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
